FILE: src/linear_resampler_biquad_antialias_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef LINEAR_RESAMPLER_BIQUAD_ANTIALIAS_CORE_MACROS_SVH
`define LINEAR_RESAMPLER_BIQUAD_ANTIALIAS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRBAA_CHECK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRBAA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lrbaa_pkg.sv
`timescale 1ns / 1ps

package lrbaa_pkg;

  // Fixed field widths
  localparam int COEF_W     = 32;
  localparam int RATIO_W    = 23;
  localparam int MODE_W     = 2;
  localparam int PHASE_W    = 24;
  localparam int PHASE_FRAC = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 3;

  localparam logic [PHASE_W-1:0] PHASE_ONE   = PHASE_W'(1) << PHASE_FRAC;
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);

  // Biquad sequencer: five multiplies, then the rounding step
  localparam logic [STEP_W-1:0] BQ_LAST_MUL  = 3'd4;
  localparam logic [STEP_W-1:0] BQ_LAST_STEP = 3'd6;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO_STEP  = 3'd0,
    CFG_FILTER_MODE = 3'd1,
    CFG_COEF_B0     = 3'd2,
    CFG_COEF_B1     = 3'd3,
    CFG_COEF_B2     = 3'd4,
    CFG_COEF_A1     = 3'd5,
    CFG_COEF_A2     = 3'd6
  } cfg_idx_t;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POST = 2'd2;

  // Shared multiplier operand select; biquad codes follow the step count
  typedef enum logic [STEP_W-1:0] {
    MUL_B0     = 3'd0,
    MUL_B1     = 3'd1,
    MUL_B2     = 3'd2,
    MUL_A1     = 3'd3,
    MUL_A2     = 3'd4,
    MUL_INTERP = 3'd5
  } mul_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     bq_finish;
    logic     bq_post;
    logic     interp_fin;
    logic     emit;
    logic     emit_last;
    logic     prime;
    logic     end_item;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode_pre;
    logic mode_post;
    logic phase_lt_one;
    logic next_lt_one;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/lrbaa_ctrl.sv
`timescale 1ns / 1ps

module lrbaa_ctrl #(
  parameter int MAX_RUN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrbaa_pkg::dp_stat_t stat,
  output lrbaa_pkg::dp_cmd_t  cmd
);

  localparam int RUN_W = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;
  localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MAX_RUN - 1);

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_PRE_BQ     = 8'b0000_0010,
    ST_DECIDE     = 8'b0000_0100,
    ST_INTERP_MUL = 8'b0000_1000,
    ST_INTERP_FIN = 8'b0001_0000,
    ST_POST_BQ    = 8'b0010_0000,
    ST_EMIT       = 8'b0100_0000,
    ST_END        = 8'b1000_0000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [lrbaa_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [RUN_W-1:0]               run_r, run_nxt;
  logic                           primed_r, primed_nxt;
  logic                           in_bq;
  logic                           run_done;

  assign in_stall = (state_r != ST_IDLE);
  assign in_bq    = (state_r == ST_PRE_BQ) || (state_r == ST_POST_BQ);
  assign run_done = !stat.next_lt_one || (run_r == RUN_LAST);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    run_nxt    = run_r;
    primed_nxt = primed_r;

    cmd           = '0;
    cmd.mul_sel   = lrbaa_pkg::MUL_B0;
    cmd.bq_post   = (state_r == ST_POST_BQ);
    cmd.emit_last = run_done;

    // biquad step sequencing, shared by pre and post filtering
    if (in_bq) begin
      cmd.mul_en    = (step_r <= lrbaa_pkg::BQ_LAST_MUL);
      cmd.mul_sel   = lrbaa_pkg::mul_sel_t'(step_r);
      cmd.acc_clr   = (step_r == '0);
      cmd.acc_add   = (step_r != '0) && (step_r != lrbaa_pkg::BQ_LAST_STEP);
      cmd.bq_finish = (step_r == lrbaa_pkg::BQ_LAST_STEP);
      step_nxt      = step_r + 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = stat.mode_pre ? ST_PRE_BQ : ST_DECIDE;
        end
      end
      ST_PRE_BQ: begin
        if (step_r == lrbaa_pkg::BQ_LAST_STEP) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        run_nxt = '0;
        if (!primed_r) begin
          cmd.prime  = 1'b1;
          primed_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (stat.phase_lt_one) begin
          state_nxt = ST_INTERP_MUL;
        end else begin
          state_nxt = ST_END;
        end
      end
      ST_INTERP_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lrbaa_pkg::MUL_INTERP;
        state_nxt   = ST_INTERP_FIN;
      end
      ST_INTERP_FIN: begin
        cmd.interp_fin = 1'b1;
        step_nxt       = '0;
        state_nxt      = stat.mode_post ? ST_POST_BQ : ST_EMIT;
      end
      ST_POST_BQ: begin
        if (step_r == lrbaa_pkg::BQ_LAST_STEP) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          run_nxt   = run_r + 1'b1;
          state_nxt = run_done ? ST_END : ST_INTERP_MUL;
        end
      end
      ST_END: begin
        cmd.end_item = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      run_r    <= '0;
      primed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      run_r    <= run_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

FILE: src/lrbaa_dp.sv
`timescale 1ns / 1ps

module lrbaa_dp #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [lrbaa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrbaa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  output logic                                 out_last_of_run,
  input  lrbaa_pkg::dp_cmd_t                   cmd,
  output lrbaa_pkg::dp_stat_t                  stat
);

  localparam int S      = SAMPLE_BITS;
  localparam int CW     = lrbaa_pkg::COEF_W;
  localparam int DIFF_W = S + 1;
  localparam int PROD_W = CW + DIFF_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int PW     = lrbaa_pkg::PHASE_W;
  localparam int PF     = lrbaa_pkg::PHASE_FRAC;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = $signed({{(ACC_W-S+1){1'b0}}, {(S-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_LO = $signed({{(ACC_W-S+1){1'b1}}, {(S-1){1'b0}}});

  // Configuration
  logic [lrbaa_pkg::RATIO_W-1:0] ratio_r, ratio_nxt;
  logic [lrbaa_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic signed [CW-1:0]          b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [CW-1:0]          b0_nxt, b1_nxt, b2_nxt, a1_nxt, a2_nxt;

  // Sample state and filter history
  logic signed [S-1:0] x_r, x_nxt;
  logic signed [S-1:0] held_r, held_nxt;
  logic signed [S-1:0] v_r, v_nxt;
  logic signed [S-1:0] hx1_r, hx2_r, hy1_r, hy2_r;
  logic signed [S-1:0] hx1_nxt, hx2_nxt, hy1_nxt, hy2_nxt;
  logic [PW-1:0]       phase_r, phase_nxt;
  logic [PW-1:0]       phase_step;

  // Multiplier and accumulator
  logic signed [CW-1:0]     mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     sub_r, sub_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-1:0]  acc_shr;
  logic signed [S-1:0]      bq_y;
  logic signed [S-1:0]      bq_xin;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] interp_sum;
  logic                     pass_mode;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic signed [S-1:0] out_sample_r, out_sample_nxt;
  logic                out_last_r, out_last_nxt;

  // Status
  assign pass_mode  = (mode_r != lrbaa_pkg::MODE_PRE) && (mode_r != lrbaa_pkg::MODE_POST);
  assign phase_step = phase_r + PW'(ratio_r);

  assign stat.mode_pre     = (mode_r == lrbaa_pkg::MODE_PRE);
  assign stat.mode_post    = (mode_r == lrbaa_pkg::MODE_POST);
  assign stat.phase_lt_one = (phase_r < lrbaa_pkg::PHASE_ONE);
  assign stat.next_lt_one  = (phase_step < lrbaa_pkg::PHASE_ONE);
  assign stat.out_free     = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_last_of_run = out_last_r;

  // Shared multiplier operands
  assign bq_xin = cmd.bq_post ? v_r : x_r;
  assign diff   = DIFF_W'(x_r) - DIFF_W'(held_r);

  always_comb begin
    case (cmd.mul_sel)
      lrbaa_pkg::MUL_B0: begin
        mul_a = b0_r;
        mul_b = DIFF_W'(bq_xin);
      end
      lrbaa_pkg::MUL_B1: begin
        mul_a = b1_r;
        mul_b = DIFF_W'(hx1_r);
      end
      lrbaa_pkg::MUL_B2: begin
        mul_a = b2_r;
        mul_b = DIFF_W'(hx2_r);
      end
      lrbaa_pkg::MUL_A1: begin
        mul_a = a1_r;
        mul_b = DIFF_W'(hy1_r);
      end
      lrbaa_pkg::MUL_A2: begin
        mul_a = a2_r;
        mul_b = DIFF_W'(hy2_r);
      end
      lrbaa_pkg::MUL_INTERP: begin
        mul_a = $signed({{(CW-PF){1'b0}}, phase_r[PF-1:0]});
        mul_b = diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Filter rounding: add half, floor shift, saturate
  assign prod_ext = ACC_W'(prod_r);
  assign acc_rnd  = acc_r + ROUND_HALF;
  assign acc_shr  = acc_rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (acc_shr > SAT_HI) begin
      bq_y = SAT_HI[S-1:0];
    end else if (acc_shr < SAT_LO) begin
      bq_y = SAT_LO[S-1:0];
    end else begin
      bq_y = acc_shr[S-1:0];
    end
  end

  // Interpolated value always lies between held and new sample
  assign interp_sum = (prod_r >>> PF) + PROD_W'(held_r);

  // Next-state logic
  always_comb begin
    ratio_nxt = ratio_r;
    mode_nxt  = mode_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    b2_nxt    = b2_r;
    a1_nxt    = a1_r;
    a2_nxt    = a2_r;

    x_nxt     = x_r;
    held_nxt  = held_r;
    v_nxt     = v_r;
    hx1_nxt   = hx1_r;
    hx2_nxt   = hx2_r;
    hy1_nxt   = hy1_r;
    hy2_nxt   = hy2_r;
    phase_nxt = phase_r;
    prod_nxt  = prod_r;
    sub_nxt   = sub_r;
    acc_nxt   = acc_r;

    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;

    // register writes; unknown indexes fall through
    if (cfg_wr_en) begin
      case (cfg_index)
        lrbaa_pkg::CFG_RATIO_STEP:  ratio_nxt = cfg_wdata[lrbaa_pkg::RATIO_W-1:0];
        lrbaa_pkg::CFG_FILTER_MODE: mode_nxt  = cfg_wdata[lrbaa_pkg::MODE_W-1:0];
        lrbaa_pkg::CFG_COEF_B0:     b0_nxt    = $signed(cfg_wdata);
        lrbaa_pkg::CFG_COEF_B1:     b1_nxt    = $signed(cfg_wdata);
        lrbaa_pkg::CFG_COEF_B2:     b2_nxt    = $signed(cfg_wdata);
        lrbaa_pkg::CFG_COEF_A1:     a1_nxt    = $signed(cfg_wdata);
        lrbaa_pkg::CFG_COEF_A2:     a2_nxt    = $signed(cfg_wdata);
        default: ;
      endcase
    end

    if (cmd.load_in) begin
      x_nxt = in_sample_in;
    end

    // multiplier stage
    if (cmd.mul_en) begin
      prod_nxt = mul_p;
      sub_nxt  = (cmd.mul_sel == lrbaa_pkg::MUL_A1) || (cmd.mul_sel == lrbaa_pkg::MUL_A2);
    end

    // accumulator
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (cmd.acc_add) begin
      acc_nxt = sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end

    // biquad result and history shift
    if (cmd.bq_finish) begin
      hx2_nxt = hx1_r;
      hx1_nxt = bq_xin;
      hy2_nxt = hy1_r;
      hy1_nxt = bq_y;
      if (cmd.bq_post) begin
        v_nxt = bq_y;
      end else begin
        x_nxt = bq_y;
      end
    end

    if (cmd.interp_fin) begin
      v_nxt = interp_sum[S-1:0];
    end

    // hand a word to the output register and step the phase
    if (cmd.emit) begin
      out_sample_nxt = v_r;
      out_last_nxt   = cmd.emit_last;
      out_valid_nxt  = 1'b1;
      phase_nxt      = phase_step;
      if (pass_mode) begin
        hx2_nxt = hx1_r;
        hx1_nxt = v_r;
        hy2_nxt = hy1_r;
        hy1_nxt = v_r;
      end
    end

    if (cmd.prime) begin
      held_nxt = x_r;
    end

    // end of item: drop one whole sample of phase, or clear it if below one
    if (cmd.end_item) begin
      held_nxt  = x_r;
      phase_nxt = stat.phase_lt_one ? '0 : (phase_r - lrbaa_pkg::PHASE_ONE);
    end
  end

  // State registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r     <= lrbaa_pkg::RATIO_RESET;
      mode_r      <= lrbaa_pkg::MODE_PASS;
      b0_r        <= '0;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      held_r      <= '0;
      hx1_r       <= '0;
      hx2_r       <= '0;
      hy1_r       <= '0;
      hy2_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ratio_r     <= ratio_nxt;
      mode_r      <= mode_nxt;
      b0_r        <= b0_nxt;
      b1_r        <= b1_nxt;
      b2_r        <= b2_nxt;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
      held_r      <= held_nxt;
      hx1_r       <= hx1_nxt;
      hx2_r       <= hx2_nxt;
      hy1_r       <= hy1_nxt;
      hy2_r       <= hy2_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    v_r          <= v_nxt;
    prod_r       <= prod_nxt;
    sub_r        <= sub_nxt;
    acc_r        <= acc_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

FILE: src/linear_resampler_biquad_antialias_core.sv
`timescale 1ns / 1ps
// Each input word causes 0..MAX_RUN outputs; the first (priming) word causes none. A new input
// word is taken only in idle, after all outputs of the last word went to the output register.
// Output stall holds the sequencer. Work per word is set by the single shared multiplier: one
// interpolation multiply per output and five filter multiplies plus a rounding step per filtered sample.
// Synchronous active-low reset clears the sequencer, phase, held sample, history and config.
module linear_resampler_biquad_antialias_core #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28,
  parameter int MAX_RUN        = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lrbaa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrbaa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    out_sample_out,
  output logic                             out_last_of_run
);

  lrbaa_pkg::dp_cmd_t  cmd;
  lrbaa_pkg::dp_stat_t stat;

  // Sequencer
  lrbaa_ctrl #(
    .MAX_RUN (MAX_RUN)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, state and output register
  lrbaa_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_sample_in    (in_sample_in),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_sample_out  (out_sample_out),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

FILE: src/lrbaa_checker.sv
`timescale 1ns / 1ps
`include "linear_resampler_biquad_antialias_core_macros.svh"

module lrbaa_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_sample_out,
  input logic                   out_last_of_run
);

  // A stalled output word holds
  `LRBAA_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample_out) && $stable(out_last_of_run), "output word changed under stall")

  // One word in flight: an accepted input blocks the next cycle
  `LRBAA_CHECK_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "input taken while busy")

  // Reset leaves no output pending
  `LRBAA_CHECK_SAME(a_rst_clean, $rose(rst_n), !out_valid, "output valid right after reset")

endmodule

bind linear_resampler_biquad_antialias_core lrbaa_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lrbaa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_sample_out  (out_sample_out),
  .out_last_of_run (out_last_of_run)
);

FILE: verif/tb_linear_resampler_biquad_antialias_core.sv
`timescale 1ns / 1ps

module tb_linear_resampler_biquad_antialias_core;
  import lrbaa_pkg::*;

  localparam int SAMPLE_W = 24;
  localparam int COEF_FRAC = 28;
  localparam int RUN_CAP = 64;
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 23'h7F_FFFF;
  localparam logic [RATIO_W-1:0] RATIO_UNITY = 23'd65536;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 600;
  localparam longint CYCLE_LIMIT = 3_000_000;

  // DUT ports
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   in_sample_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]   out_sample_out;
  logic                         out_last_of_run;

  linear_resampler_biquad_antialias_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the registers and the resampler state
  logic [RATIO_W-1:0] m_ratio = RATIO_RESET;
  logic [MODE_W-1:0]  m_mode = MODE_PASS;
  longint             m_b0 = 0, m_b1 = 0, m_b2 = 0, m_a1 = 0, m_a2 = 0;
  longint             held_smp = 0;
  int unsigned        phase_acc = 0;
  bit                 primed = 1'b0;
  longint             hx1 = 0, hx2 = 0, hy1 = 0, hy2 = 0;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
  } out_word_t;

  out_word_t                  pending_outputs[$];
  logic signed [SAMPLE_W-1:0] src_q[$];

  int     offered = 0;
  int     accepted = 0;
  int     mismatch_cnt = 0;
  longint cycle_cnt = 0;
  bit     idle_en = 1'b1;
  bit     long_hold_req = 1'b0;
  int     in_gap = 0;
  int     out_gap = 0;
  int     hold_cnt = 0;

  function automatic longint clip_sample(longint v);
    if (v > SAMPLE_HI) return SAMPLE_HI;
    if (v < SAMPLE_LO) return SAMPLE_LO;
    return v;
  endfunction

  // Direct-form-I biquad, round half up, history keeps saturated values
  function automatic longint lowpass(longint x);
    longint acc;
    longint y;
    acc = m_b0 * x + m_b1 * hx1 + m_b2 * hx2 - m_a1 * hy1 - m_a2 * hy2;
    y = clip_sample((acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC);
    hx2 = hx1;
    hx1 = x;
    hy2 = hy1;
    hy1 = y;
    return y;
  endfunction

  // Expected output words for one accepted source sample
  function automatic void resample_item(logic signed [SAMPLE_W-1:0] smp);
    longint    x;
    longint    v;
    longint    run [RUN_CAP];
    int        n;
    int        k;
    out_word_t w;
    n = 0;
    x = longint'(smp);
    if (m_mode == MODE_PRE) x = lowpass(x);
    if (!primed) begin
      held_smp = x;
      primed = 1'b1;
      return;
    end
    while (phase_acc < PHASE_ONE && n < RUN_CAP) begin
      v = clip_sample(held_smp + (((x - held_smp) * longint'(phase_acc)) >>> PHASE_FRAC));
      if (m_mode == MODE_POST) v = lowpass(v);
      run[n] = v;
      n++;
      phase_acc += m_ratio;
    end
    // run cap drops whatever phase is left
    if (phase_acc < PHASE_ONE) phase_acc = PHASE_ONE;
    phase_acc = (phase_acc - PHASE_ONE) & 32'h00FF_FFFF;
    held_smp = x;
    // pass and spare modes refresh history from the outputs
    if (m_mode != MODE_PRE && m_mode != MODE_POST && n > 0) begin
      if (n > 1) begin
        hx2 = run[n-2];
        hy2 = run[n-2];
      end else begin
        hx2 = hx1;
        hy2 = hy1;
      end
      hx1 = run[n-1];
      hy1 = run[n-1];
    end
    for (k = 0; k < n; k++) begin
      w.smp = run[k][SAMPLE_W-1:0];
      w.last = (k == n - 1);
      pending_outputs.push_back(w);
    end
  endfunction

  // Random words, smooth walks and some extremes
  function automatic logic signed [SAMPLE_W-1:0] next_sample(logic signed [SAMPLE_W-1:0] prev);
    logic [31:0] r;
    longint      delta;
    r = $urandom;
    delta = longint'($urandom_range(0, 8192)) - 4096;
    case (r[2:0])
      3'd0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      3'd1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      3'd2, 3'd3, 3'd4: return r[31:8];
      default: return SAMPLE_W'(clip_sample(longint'(prev) + delta));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RATIO_STEP:  m_ratio = val[RATIO_W-1:0];
      CFG_FILTER_MODE: m_mode = val[MODE_W-1:0];
      CFG_COEF_B0:     m_b0 = longint'(signed'(val));
      CFG_COEF_B1:     m_b1 = longint'(signed'(val));
      CFG_COEF_B2:     m_b2 = longint'(signed'(val));
      CFG_COEF_A1:     m_a1 = longint'(signed'(val));
      CFG_COEF_A2:     m_a2 = longint'(signed'(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Block drained: nothing queued, nothing on the bus, no output owed
  task automatic wait_idle();
    while (src_q.size() != 0 || offered != accepted || pending_outputs.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(logic [RATIO_W-1:0] ratio, logic [MODE_W-1:0] mode,
                             logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
                             logic [31:0] a1, logic [31:0] a2);
    wait_idle();
    write_reg(CFG_RATIO_STEP, CFG_DATA_W'(ratio));
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_COEF_B0, b0);
    write_reg(CFG_COEF_B1, b1);
    write_reg(CFG_COEF_B2, b2);
    write_reg(CFG_COEF_A1, a1);
    write_reg(CFG_COEF_A2, a2);
  endtask

  // Source side: holds a word until taken, random gap bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (offered != accepted) begin
      // word still waiting on the bus
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (src_q.size() != 0 && idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      in_gap = $urandom_range(0, 15);
    end else if (src_q.size() != 0) begin
      in_sample_in <= src_q.pop_front();
      in_valid <= 1'b1;
      offered++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Sink side: one long hold on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_req && hold_cnt < LONG_HOLD) begin
      out_stall <= 1'b1;
      hold_cnt++;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      out_gap = $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Handshake monitor: predict on input, compare on output
  always @(posedge clk) begin : mon
    out_word_t w;
    cycle_cnt++;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        accepted++;
        resample_item(in_sample_in);
      end
      if (out_valid && !out_stall) begin
        if (pending_outputs.size() == 0) begin
          $error("output word with nothing expected: sample_out %0d last_of_run %0b",
                 out_sample_out, out_last_of_run);
          mismatch_cnt++;
        end else begin
          w = pending_outputs.pop_front();
          if (out_sample_out !== w.smp) begin
            $error("sample_out: expected %0d, got %0d", w.smp, out_sample_out);
            mismatch_cnt++;
          end
          if (out_last_of_run !== w.last) begin
            $error("last_of_run: expected %0b, got %0b", w.last, out_last_of_run);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    logic signed [SAMPLE_W-1:0] s;
    logic [RATIO_W-1:0]         r;
    logic [31:0]                b0, b1, b2, a1, a2;
    int                         cat;
    int                         n_items;
    int                         n_rand;

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset settings: priming word, then extremes at unity ratio
    src_q.push_back(24'sh7F_FFFF);
    src_q.push_back(24'sh80_0000);
    src_q.push_back(24'sh7F_FFFF);
    src_q.push_back(24'sh00_0000);
    src_q.push_back(24'shFF_FFFF);
    src_q.push_back(24'sh00_0001);
    src_q.push_back(24'sh80_0000);

    // zero ratio hits the run cap; spare mode; write to a missing register
    load_config('0, MODE_SPARE, '0, '0, '0, '0, '0);
    write_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
    src_q.push_back(24'sh7F_FFFF);
    src_q.push_back(24'sh80_0000);

    // slowest ratio that stays within the run cap, post filter with extreme coefficients
    load_config(23'd1024, MODE_POST, 32'h1000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000);
    src_q.push_back(24'sh80_0000);
    src_q.push_back(24'sh7F_FFFF);
    src_q.push_back(24'sh00_3039);

    // fastest ratio, pre filter: mostly words that yield nothing
    load_config(RATIO_MAX, MODE_PRE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF);
    src_q.push_back(24'sh7F_FFFF);
    src_q.push_back(24'sh80_0000);
    src_q.push_back(24'sh00_0000);
    src_q.push_back(24'shFF_FFFF);
    src_q.push_back(24'sh7F_FFFF);
    src_q.push_back(24'sh7F_FFFF);
    src_q.push_back(24'sh80_0000);
    src_q.push_back(24'sh00_0001);

    // random settings per phase
    s = '0;
    n_rand = 0;
    while (n_rand < 390) begin
      cat = $urandom_range(0, 15);
      if (cat == 0) r = $urandom_range(0, 1023);
      else if (cat <= 2) r = $urandom_range(1024, 8191);
      else if (cat <= 10) r = $urandom_range(8192, 131072);
      else if (cat <= 13) r = $urandom_range(131073, 1048576);
      else r = $urandom_range(1048577, RATIO_MAX);
      n_items = (cat <= 2) ? 10 : 36;
      if ($urandom_range(0, 1) == 0) begin
        // roughly low-pass shaped
        b0 = $urandom_range(0, 1 << 26);
        b1 = b0 << 1;
        b2 = b0;
        a1 = -$urandom_range(1 << 27, 1 << 29);
        a2 = $urandom_range(0, 1 << 27);
      end else begin
        b0 = $urandom;
        b1 = $urandom;
        b2 = $urandom;
        a1 = $urandom;
        a2 = $urandom;
      end
      load_config(r, MODE_W'($urandom_range(0, 3)), b0, b1, b2, a1, a2);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_IDX, $urandom);
      idle_en = ($urandom_range(0, 3) != 0);
      repeat (n_items) begin
        s = next_sample(s);
        src_q.push_back(s);
      end
      n_rand += n_items;
    end

    // long output hold while words keep coming, so the input backs up
    load_config(23'd8192, MODE_POST, 32'h0400_0000, 32'h0800_0000, 32'h0400_0000, '0, '0);
    idle_en = 1'b1;
    long_hold_req = 1'b1;
    repeat (24) begin
      s = next_sample(s);
      src_q.push_back(s);
    end

    // closing stretch at full rate
    load_config(RATIO_UNITY - 23'd4096, MODE_PASS, 32'h0400_0000, 32'h0800_0000,
                32'h0400_0000, '0, '0);
    idle_en = 1'b0;
    repeat (20) begin
      s = next_sample(s);
      src_q.push_back(s);
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/lrbaa_pkg.sv
src/lrbaa_ctrl.sv
src/lrbaa_dp.sv
src/linear_resampler_biquad_antialias_core.sv
src/lrbaa_checker.sv
verif/tb_linear_resampler_biquad_antialias_core.sv
